FILE: rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque unit.
// No dependencies; used by bounded_deque_unit and its testbench.
package bdq_pkg;

   // Default sizing handed to the top level parameters
   localparam int unsigned DEPTH_DEF     = 1024;
   localparam int unsigned WORD_BITS_DEF = 32;

   // Request codes; the three unused codes behave as a peek
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_PEEK       = 3'd4;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Request word
   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] push_value;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic [10:0]        entry_count;
      logic               is_empty;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_word_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

FILE: rtl/bdq_ring_mem.sv
// Ring store of the deque: one write port, one read port, registered read data.
// Depends on nothing; sized by the parameters of the top level.
module bdq_ring_mem #(
   parameter int unsigned DEPTH     = 1024,
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]     rd_data
);

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bounded_deque_unit.sv
// Bounded deque unit: double-ended queue of signed words in a ring store.
// Results are registered; a pop that leaves the queue non-empty also passes
// through the read state (the new end word is read from the ring store port).
// Flow: one request in flight at a time; a new request waits while a result is held.
// Reset: synchronous; resets the count and indices, queue reads as empty.
// Store contents are not cleared; entries are only read after being pushed.
module bounded_deque_unit #(
   parameter int unsigned DEPTH     = bdq_pkg::DEPTH_DEF,
   parameter int unsigned WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bdq_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bdq_pkg::rsp_word_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   // Control state
   bdq_pkg::state_type    state_ff, state_in;
   logic [IDX_W-1:0]      front_idx_ff, front_idx_in;
   logic [IDX_W-1:0]      back_idx_ff, back_idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Cached end words and pending read side
   logic signed [31:0]    front_word_ff, front_word_in;
   logic signed [31:0]    back_word_ff, back_word_in;
   logic                  rd_front_ff, rd_front_in;
   bdq_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   // Request decode and memory port
   logic                  accept;
   logic                  need_read;
   logic                  mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]      mem_wr_addr, mem_rd_addr;
   logic [WORD_BITS-1:0]  wr_word, rd_word;
   logic signed [31:0]    wr_ext, rd_ext;
   logic signed [31:0]    popped;
   logic [1:0]            status;
   logic [IDX_W-1:0]      front_prev, front_next, back_prev, back_next;
   logic                  is_full, is_empty_now;

   assign accept = req_valid && req_ready;

   // Word width conversion: store keeps WORD_BITS, outputs sign-extend to 32
   assign wr_word = WORD_BITS'(req_data.push_value);
   assign wr_ext  = 32'($signed(wr_word));
   assign rd_ext  = 32'($signed(rd_word));

   // Ring index neighbors
   assign front_prev = (front_idx_ff == '0) ? LAST_IDX : front_idx_ff - IDX_W'(1);
   assign front_next = (front_idx_ff == LAST_IDX) ? '0 : front_idx_ff + IDX_W'(1);
   assign back_prev  = (back_idx_ff == '0) ? LAST_IDX : back_idx_ff - IDX_W'(1);
   assign back_next  = (back_idx_ff == LAST_IDX) ? '0 : back_idx_ff + IDX_W'(1);

   assign is_full      = (cnt_ff == FULL_CNT);
   assign is_empty_now = (cnt_ff == '0);

   // Request processing: pointers, count, caches and store access
   always_comb begin
      front_idx_in  = front_idx_ff;
      back_idx_in   = back_idx_ff;
      cnt_in        = cnt_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      rd_front_in   = rd_front_ff;
      popped        = '0;
      status        = bdq_pkg::STAT_OK;
      need_read     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = front_prev;
      mem_rd_addr   = front_next;
      if (accept) begin
         case (req_data.req_type)
            bdq_pkg::REQ_PUSH_FRONT: begin
               if (is_full) begin
                  status = bdq_pkg::STAT_FULL;
               end else begin
                  front_idx_in  = front_prev;
                  cnt_in        = cnt_ff + ONE_CNT;
                  front_word_in = wr_ext;
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = front_prev;
                  if (is_empty_now) begin
                     back_word_in = wr_ext;
                  end
               end
            end
            bdq_pkg::REQ_PUSH_BACK: begin
               if (is_full) begin
                  status = bdq_pkg::STAT_FULL;
               end else begin
                  back_idx_in  = back_next;
                  cnt_in       = cnt_ff + ONE_CNT;
                  back_word_in = wr_ext;
                  mem_wr_en    = 1'b1;
                  mem_wr_addr  = back_next;
                  if (is_empty_now) begin
                     front_word_in = wr_ext;
                  end
               end
            end
            bdq_pkg::REQ_POP_FRONT: begin
               if (is_empty_now) begin
                  status = bdq_pkg::STAT_EMPTY;
               end else begin
                  popped       = front_word_ff;
                  front_idx_in = front_next;
                  cnt_in       = cnt_ff - ONE_CNT;
                  mem_rd_addr  = front_next;
                  need_read    = (cnt_ff != ONE_CNT);
                  rd_front_in  = 1'b1;
               end
            end
            bdq_pkg::REQ_POP_BACK: begin
               if (is_empty_now) begin
                  status = bdq_pkg::STAT_EMPTY;
               end else begin
                  popped      = back_word_ff;
                  back_idx_in = back_prev;
                  cnt_in      = cnt_ff - ONE_CNT;
                  mem_rd_addr = back_prev;
                  need_read   = (cnt_ff != ONE_CNT);
                  rd_front_in = 1'b0;
               end
            end
            default: begin
               // peek and unused codes leave the state alone
            end
         endcase
      end else if (state_ff == bdq_pkg::ST_READ) begin
         // new end word arrives from the store
         if (rd_front_ff) begin
            front_word_in = rd_ext;
         end else begin
            back_word_in = rd_ext;
         end
      end
   end

   // Result word assembly
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_data_in.popped_value = popped;
         rsp_data_in.status       = status;
         rsp_data_in.entry_count  = 11'(cnt_in);
         rsp_data_in.is_empty     = (cnt_in == '0);
         rsp_data_in.front_value  = (cnt_in == '0) ? 32'sd0 : front_word_in;
         rsp_data_in.back_value   = (cnt_in == '0) ? 32'sd0 : back_word_in;
      end else if (state_ff == bdq_pkg::ST_READ) begin
         rsp_data_in.front_value = front_word_in;
         rsp_data_in.back_value  = back_word_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept && need_read) begin
               state_in = bdq_pkg::ST_READ;
            end
         end
         bdq_pkg::ST_READ: begin
            state_in = bdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bdq_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs: request ready, store read enable, result valid
   always_comb begin
      req_ready    = 1'b0;
      mem_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            mem_rd_en = accept && need_read;
            if (accept && !need_read) begin
               rsp_valid_in = 1'b1;
            end
         end
         bdq_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         front_idx_ff <= '0;
         back_idx_ff  <= LAST_IDX;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      rd_front_ff   <= rd_front_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Ring store; pops never write, so a read never meets a same-cycle write
   bdq_ring_mem #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (wr_word),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_word)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::ST_READ) |-> !rsp_valid_ff)
      else $error("result register busy while store read in flight");

   a_read_gives_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::ST_READ) |=> rsp_valid_ff)
      else $error("store read did not produce a result word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::ST_READ) |-> !req_ready)
      else $error("request accepted during store read");

endmodule

FILE: tb/sv/bounded_deque_unit_test.sv
// Self-checking testbench for bounded_deque_unit: sends request words, predicts
// each result word with a local deque model and compares the words field by field.
// Depends on bdq_pkg (rtl/bdq_pkg.sv) and rtl/bounded_deque_unit.sv.
module bounded_deque_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH            = bdq_pkg::DEPTH_DEF;
   localparam int unsigned IDLE_PCT         = 22;
   localparam int unsigned SHOWN_MISMATCHES = 10;

   // unassigned request codes, handled as a peek
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   bdq_pkg::req_word_type req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   bdq_pkg::rsp_word_type rsp_data;

   // no idling on either side while set
   logic        steady         = 1'b0;
   int unsigned mismatch_count = 0;

   // predictor state: ring of words, end slots and word count
   logic signed [31:0]    deque_words [DEPTH];
   int unsigned           head_slot  = 0;
   int unsigned           tail_slot  = DEPTH - 1;
   int unsigned           word_total = 0;
   bdq_pkg::rsp_word_type pending_results [$];

   bounded_deque_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("bounded_deque_unit_test failed");
      $finish;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // apply one request to the local deque and return the result word it yields
   function automatic bdq_pkg::rsp_word_type predict_deque_step(bdq_pkg::req_word_type w);
      bdq_pkg::rsp_word_type r;
      r = '0;
      r.status = bdq_pkg::STAT_OK;
      case (w.req_type)
         bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
            if (word_total == DEPTH) begin
               r.status = bdq_pkg::STAT_FULL;
            end else if (w.req_type == bdq_pkg::REQ_PUSH_FRONT) begin
               head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
               deque_words[head_slot] = w.push_value;
               word_total++;
            end else begin
               tail_slot = (tail_slot == DEPTH - 1) ? 0 : tail_slot + 1;
               deque_words[tail_slot] = w.push_value;
               word_total++;
            end
         end
         bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
            if (word_total == 0) begin
               r.status = bdq_pkg::STAT_EMPTY;
            end else if (w.req_type == bdq_pkg::REQ_POP_FRONT) begin
               r.popped_value = deque_words[head_slot];
               head_slot = (head_slot == DEPTH - 1) ? 0 : head_slot + 1;
               word_total--;
            end else begin
               r.popped_value = deque_words[tail_slot];
               tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
               word_total--;
            end
         end
         default: ;
      endcase
      r.entry_count = 11'(word_total);
      r.is_empty    = (word_total == 0);
      if (word_total != 0) begin
         r.front_value = deque_words[head_slot];
         r.back_value  = deque_words[tail_slot];
      end
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
   endtask

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : result_check
      bdq_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
               $display("%0t: result word with none expected: %h", $time, rsp_data);
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            check_field("popped_value", want.popped_value, rsp_data.popped_value);
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_data.entry_count));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
            check_field("front_value", want.front_value, rsp_data.front_value);
            check_field("back_value", want.back_value, rsp_data.back_value);
         end
      end
   end

   // send one request word; returns at the edge where it is taken
   task automatic send_request(input logic [2:0] code, input logic signed [31:0] value);
      bdq_pkg::req_word_type w;
      w.req_type   = code;
      w.push_value = value;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(), predict_deque_step(w));
   endtask

   // weighted pick of a request code; the remainder goes to the spare codes
   function automatic logic [2:0] pick_code(int unsigned push_pct, int unsigned pop_pct,
                                            int unsigned peek_pct);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < push_pct)
         return $urandom_range(1) ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT;
      if (roll < push_pct + pop_pct)
         return $urandom_range(1) ? bdq_pkg::REQ_POP_BACK : bdq_pkg::REQ_POP_FRONT;
      if (roll < push_pct + pop_pct + peek_pct)
         return bdq_pkg::REQ_PEEK;
      return 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
   endfunction

   // empty pops, peeks, spare codes and extreme words at both ends
   task automatic test_directed_edges();
      send_request(bdq_pkg::REQ_POP_FRONT, $urandom());
      send_request(bdq_pkg::REQ_POP_BACK, $urandom());
      send_request(bdq_pkg::REQ_PEEK, $urandom());
      for (int c = int'(REQ_SPARE_FIRST); c <= int'(REQ_SPARE_LAST); c++)
         send_request(3'(c), $urandom());
      send_request(bdq_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(bdq_pkg::REQ_PUSH_BACK, 32'sh8000_0000);
      send_request(bdq_pkg::REQ_PUSH_FRONT, -32'sd1);
      send_request(bdq_pkg::REQ_PUSH_BACK, '0);
      send_request(bdq_pkg::REQ_PEEK, $urandom());
      send_request(bdq_pkg::REQ_POP_BACK, $urandom());
      send_request(bdq_pkg::REQ_POP_FRONT, $urandom());
      send_request(bdq_pkg::REQ_POP_FRONT, $urandom());
      send_request(bdq_pkg::REQ_POP_BACK, $urandom());
      send_request(bdq_pkg::REQ_POP_BACK, $urandom());
      send_request(bdq_pkg::REQ_PUSH_BACK, 32'sh5555_5555);
      send_request(bdq_pkg::REQ_POP_FRONT, $urandom());
      send_request(bdq_pkg::REQ_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(bdq_pkg::REQ_PUSH_FRONT, 32'sh0000_0001);
      send_request(REQ_SPARE_LAST, $urandom());
      send_request(bdq_pkg::REQ_POP_BACK, $urandom());
      send_request(bdq_pkg::REQ_POP_BACK, $urandom());
   endtask

   // balanced traffic near empty; the count walks up and down
   task automatic test_random_mix(int unsigned count);
      repeat (count) send_request(pick_code(40, 40, 12), $urandom());
   endtask

   // mostly pushes on both ends until the ring is full; both indices wrap
   task automatic test_fill_to_capacity();
      while (word_total < DEPTH) begin
         steady <= (word_total >= 300 && word_total < 650);
         send_request(pick_code(95, 3, 1), $urandom());
      end
      steady <= 1'b0;
   endtask

   // pushes dropped at full, then traffic hovering around full
   task automatic test_full_boundary(int unsigned count);
      send_request(bdq_pkg::REQ_PUSH_FRONT, $urandom());
      send_request(bdq_pkg::REQ_PUSH_BACK, $urandom());
      send_request(bdq_pkg::REQ_PUSH_BACK, $urandom());
      send_request(bdq_pkg::REQ_PUSH_FRONT, $urandom());
      send_request(bdq_pkg::REQ_PEEK, $urandom());
      repeat (count) send_request(pick_code(50, 40, 6), $urandom());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_random_mix(250);
      test_fill_to_capacity();
      test_full_boundary(80);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("bounded_deque_unit_test passed");
      end else begin
         $display("bounded_deque_unit_test failed");
      end
      $finish;
   end

endmodule
